// File: sv/cpu6502_subset_bus_cycle_core_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 6502 subset bus-cycle core checker
// Both macros expect clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef CPU6502_SUBSET_BUS_CYCLE_CORE_TOP_ASSERT_SVH
`define CPU6502_SUBSET_BUS_CYCLE_CORE_TOP_ASSERT_SVH

// same-cycle implication
`define C6502_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("c6502 check failed");

// next-cycle implication
`define C6502_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("c6502 check failed");

`endif

// File: sv/c6502_pkg.sv
// ----------------------------------------------------------------------------
// c6502_pkg
// Types and constants shared by the 6502 subset bus-cycle core.
// ----------------------------------------------------------------------------
package c6502_pkg;

  typedef enum logic [2:0] {
    PH_VEC_LO = 3'd0,
    PH_VEC_HI = 3'd1,
    PH_FETCH  = 3'd2,
    PH_OP1    = 3'd3,
    PH_OP2    = 3'd4,
    PH_OP3    = 3'd5
  } phase_e;

  localparam logic [7:0] OP_BPL     = 8'h10;
  localparam logic [7:0] OP_SEI     = 8'h78;
  localparam logic [7:0] OP_STA_ABS = 8'h8D;
  localparam logic [7:0] OP_TXS     = 8'h9A;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDA_ABS = 8'hAD;
  localparam logic [7:0] OP_CLD     = 8'hD8;

  localparam int unsigned FLAG_N_BIT = 7;
  localparam int unsigned FLAG_D_BIT = 3;
  localparam int unsigned FLAG_I_BIT = 2;
  localparam int unsigned FLAG_Z_BIT = 1;

  localparam logic [15:0] VEC_LO_ADDR      = 16'hFFFC;
  localparam logic [15:0] VEC_HI_ADDR      = 16'hFFFD;
  localparam logic [7:0]  SP_RESET         = 8'hFD;
  localparam logic [15:0] FRAME_CYC_RESET  = 16'd29780;
  localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

  localparam int unsigned OUT_TDATA_W = 32;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  flags;
    logic [15:0] pc;
    logic [7:0]  sp;
    logic [7:0]  opcode;
    phase_e      phase;
    logic [15:0] latch;
    logic [15:0] fcnt;
    logic        odd;
    logic        halted;
  } core_state_t;

  typedef struct packed {
    logic        fault;
    logic        frame_end;
    logic        opcode_fetch;
    logic [7:0]  bus_wdata;
    logic        bus_write;
    logic [15:0] bus_address;
  } bus_req_t;

  localparam core_state_t CORE_RESET = '{
    acc:    8'h00,
    x:      8'h00,
    flags:  8'h00,
    pc:     16'h0000,
    sp:     SP_RESET,
    opcode: 8'h00,
    phase:  PH_VEC_LO,
    latch:  16'h0000,
    fcnt:   16'h0000,
    odd:    1'b0,
    halted: 1'b0
  };

endpackage

// File: sv/cpu6502_subset_bus_cycle_core_top.sv
// Output: the bus access for an accepted word is registered in out_data_q for m_axis.
// Throughput: one word per cycle while m_axis_tready is high; the next-access logic is
// one combinational pass between the core state registers and the output register.
// The output register decouples the sides: input is taken while a result waits
// if m_axis_tready is high in that cycle.
// Reset (rst_ni low, async): core state to CORE_RESET, frame_cycles back to 29780.
// ----------------------------------------------------------------------------
// cpu6502_subset_bus_cycle_core_top
// Cycle-level 6502 subset core: one bus access out for each completed cycle in.
// ----------------------------------------------------------------------------
module cpu6502_subset_bus_cycle_core_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] read_data
  input  logic        s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] bus_address, [16] bus_write, [24:17] bus_wdata, [25] opcode_fetch,
  // [26] frame_end, [27] fault, [31:28] zero
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import c6502_pkg::*;

  core_state_t state_q, state_d;
  bus_req_t    req;
  logic [15:0] frame_cycles_q;
  logic        out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic        accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  c6502_step u_step (
    .cur_i          (state_q),
    .cmd_i          (s_axis_tuser),
    .rdata_i        (s_axis_tdata),
    .frame_cycles_i (frame_cycles_q),
    .nxt_o          (state_d),
    .req_o          (req)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= CORE_RESET;
      frame_cycles_q <= FRAME_CYC_RESET;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) frame_cycles_q <= cfg_wdata_i;
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_data_q <= {4'd0, req};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: sv/c6502_step.sv
// ----------------------------------------------------------------------------
// c6502_step
// Next-state and next-bus-access logic for one completed bus cycle.
// ----------------------------------------------------------------------------
module c6502_step (
  input  c6502_pkg::core_state_t cur_i,
  input  logic                   cmd_i,
  input  logic [7:0]             rdata_i,
  input  logic [15:0]            frame_cycles_i,
  output c6502_pkg::core_state_t nxt_o,
  output c6502_pkg::bus_req_t    req_o
);
  import c6502_pkg::*;

  core_state_t nxt;
  bus_req_t    req;
  logic        bnd;
  logic [15:0] pc_inc;
  logic [15:0] br_off;
  logic [16:0] budget;
  logic [15:0] budget_sat;
  logic [15:0] latch_hi;

  assign pc_inc   = cur_i.pc + 16'd1;
  assign br_off   = {{8{rdata_i[7]}}, rdata_i};
  assign latch_hi = cur_i.latch | {rdata_i, 8'h00};
  assign budget   = {1'b0, frame_cycles_i} + {16'd0, cur_i.odd};
  assign budget_sat = budget[16] ? COUNT_MAX : budget[15:0];

  always_comb begin
    nxt = cur_i;
    req = '0;
    bnd = 1'b0;

    if (!cmd_i) begin
      nxt = CORE_RESET;
      req.bus_address = VEC_LO_ADDR;
    end else if (cur_i.halted) begin
      req.bus_address = cur_i.pc;
      req.fault = 1'b1;
    end else if (cur_i.phase == PH_VEC_LO) begin
      nxt.latch = {8'h00, rdata_i};
      nxt.phase = PH_VEC_HI;
      req.bus_address = VEC_HI_ADDR;
    end else if (cur_i.phase == PH_VEC_HI) begin
      nxt.pc = latch_hi;
      bnd = 1'b1;
    end else begin
      if (cur_i.fcnt != COUNT_MAX) nxt.fcnt = cur_i.fcnt + 16'd1;
      unique case (cur_i.phase)
        PH_FETCH: begin
          nxt.opcode = rdata_i;
          nxt.pc = pc_inc;
          nxt.phase = PH_OP1;
          req.bus_address = pc_inc;
          unique case (rdata_i)
            OP_SEI: nxt.flags[FLAG_I_BIT] = 1'b1;
            OP_TXS: nxt.sp = cur_i.x;
            OP_CLD: nxt.flags[FLAG_D_BIT] = 1'b0;
            OP_BPL, OP_STA_ABS, OP_LDX_IMM, OP_LDA_IMM, OP_LDA_ABS: ;
            default: begin
              nxt.halted = 1'b1;
              nxt.phase = cur_i.phase;
              req.fault = 1'b1;
            end
          endcase
        end
        PH_OP1: begin
          unique case (cur_i.opcode)
            OP_BPL: begin
              nxt.pc = pc_inc;
              if (cur_i.flags[FLAG_N_BIT]) begin
                bnd = 1'b1;
              end else begin
                nxt.latch = pc_inc + br_off;
                nxt.phase = PH_OP2;
                req.bus_address = pc_inc;
              end
            end
            OP_STA_ABS, OP_LDA_ABS: begin
              nxt.latch = {8'h00, rdata_i};
              nxt.pc = pc_inc;
              nxt.phase = PH_OP2;
              req.bus_address = pc_inc;
            end
            OP_LDX_IMM: begin
              nxt.x = rdata_i;
              nxt.pc = pc_inc;
              nxt.flags[FLAG_N_BIT] = rdata_i[7];
              nxt.flags[FLAG_Z_BIT] = (rdata_i == 8'h00);
              bnd = 1'b1;
            end
            OP_LDA_IMM: begin
              nxt.acc = rdata_i;
              nxt.pc = pc_inc;
              nxt.flags[FLAG_N_BIT] = rdata_i[7];
              nxt.flags[FLAG_Z_BIT] = (rdata_i == 8'h00);
              bnd = 1'b1;
            end
            default: bnd = 1'b1;
          endcase
        end
        PH_OP2: begin
          unique case (cur_i.opcode)
            OP_BPL: begin
              if (cur_i.latch[15:8] == cur_i.pc[15:8]) begin
                nxt.pc = cur_i.latch;
                bnd = 1'b1;
              end else begin
                // page crossed: dummy read with the unfixed high byte
                nxt.phase = PH_OP3;
                req.bus_address = {cur_i.pc[15:8], cur_i.latch[7:0]};
              end
            end
            OP_STA_ABS, OP_LDA_ABS: begin
              nxt.latch = latch_hi;
              nxt.pc = pc_inc;
              nxt.phase = PH_OP3;
              req.bus_address = latch_hi;
              if (cur_i.opcode == OP_STA_ABS) begin
                req.bus_write = 1'b1;
                req.bus_wdata = cur_i.acc;
              end
            end
            default: bnd = 1'b1;
          endcase
        end
        PH_OP3: begin
          if (cur_i.opcode == OP_BPL) begin
            nxt.pc = cur_i.latch;
          end else if (cur_i.opcode == OP_LDA_ABS) begin
            nxt.acc = rdata_i;
            nxt.flags[FLAG_N_BIT] = rdata_i[7];
            nxt.flags[FLAG_Z_BIT] = (rdata_i == 8'h00);
          end
          bnd = 1'b1;
        end
        default: bnd = 1'b1;
      endcase
    end

    // instruction boundary: frame budget check and opcode fetch
    if (bnd) begin
      if (nxt.fcnt >= budget_sat) begin
        req.frame_end = 1'b1;
        nxt.fcnt = 16'd0;
        nxt.odd = ~cur_i.odd;
      end
      nxt.phase = PH_FETCH;
      req.bus_address = nxt.pc;
      req.opcode_fetch = 1'b1;
    end
  end

  assign nxt_o = nxt;
  assign req_o = req;

endmodule

// File: sv/c6502_checker.sv
// ----------------------------------------------------------------------------
// c6502_checker
// Port-level checks on the bus-cycle core, bound to the top level.
// ----------------------------------------------------------------------------
module c6502_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  import c6502_pkg::*;
  `include "cpu6502_subset_bus_cycle_core_top_assert.svh"

  logic        out_stall;
  logic        rst_cmd;
  logic        vec_word;
  logic [15:0] m_addr;
  logic        m_wr;
  logic        m_fetch;
  logic        m_fend;
  logic        m_fault;
  logic [11:0] m_upper;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign rst_cmd   = s_axis_tvalid && s_axis_tready && !s_axis_tuser;
  assign m_addr    = m_axis_tdata[15:0];
  assign m_wr      = m_axis_tdata[16];
  assign m_fetch   = m_axis_tdata[25];
  assign m_fend    = m_axis_tdata[26];
  assign m_fault   = m_axis_tdata[27];
  assign m_upper   = m_axis_tdata[27:16];
  assign vec_word  = (m_addr == VEC_LO_ADDR) && (m_upper == 12'd0);

  // a stalled word holds
  `C6502_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
  // reset command issues the vector low read
  `C6502_ASSERT_NXT(a_reset_vec, rst_cmd, m_axis_tvalid && vec_word)
  // a halted core only reads
  `C6502_ASSERT_IMP(a_fault_read, m_axis_tvalid && m_fault, !m_wr && !m_fetch && !m_fend)
  // frame end only on an opcode fetch, which is never a write
  `C6502_ASSERT_IMP(a_fend_fetch, m_axis_tvalid && m_fend, m_fetch && !m_wr)

endmodule

bind cpu6502_subset_bus_cycle_core_top c6502_checker u_c6502_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
